// ===== hdl/image_difference_bounding_box_core_macros.svh =====
// assertion helpers for the frame difference bounding box core
`ifndef IMAGE_DIFFERENCE_BOUNDING_BOX_CORE_MACROS_SVH
`define IMAGE_DIFFERENCE_BOUNDING_BOX_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define IDBB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define IDBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/idbb_pkg.sv =====
`default_nettype none

package idbb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W   = COORD_W + 1;
  localparam int CFG_W   = 13;
  localparam int PIXEL_W = 24;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_addr_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

  typedef struct packed {
    logic               identical;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
  } result_t;

  // zero acts as one, anything above the limit is clamped
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/idbb_tracker.sv =====
`default_nettype none

module idbb_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [idbb_pkg::PIXEL_W-1:0] ref_pixel,
  input  wire logic [idbb_pkg::PIXEL_W-1:0] cmp_pixel,
  input  wire logic                        last,
  input  wire idbb_pkg::dims_t             dims,
  input  wire logic                        restart,
  input  wire idbb_pkg::dims_t             restart_dims,
  output idbb_pkg::result_t                result
);
  import idbb_pkg::*;

  logic [DIM_W-1:0]   box_min_col, box_min_col_next;
  logic [DIM_W-1:0]   box_min_row, box_min_row_next;
  logic [COORD_W-1:0] box_max_col, box_max_col_next;
  logic [COORD_W-1:0] box_max_row, box_max_row_next;
  logic               box_seen, box_seen_next;
  logic [COORD_W-1:0] col_count, col_count_next;
  logic [COORD_W-1:0] row_count, row_count_next;

  logic               diff;
  logic [DIM_W-1:0]   x_ext, y_ext;
  logic [DIM_W-1:0]   x_inc, y_inc;
  logic [DIM_W-1:0]   x0, y0, x1, y1;
  logic [DIM_W-1:0]   max_col_inc, max_row_inc;

  assign diff  = (ref_pixel != cmp_pixel);
  assign x_ext = DIM_W'(col_count);
  assign y_ext = DIM_W'(row_count);
  assign x_inc = x_ext + DIM_W'(1);
  assign y_inc = y_ext + DIM_W'(1);

  // box including the current pair
  always_comb begin
    box_min_col_next = box_min_col;
    box_min_row_next = box_min_row;
    box_max_col_next = box_max_col;
    box_max_row_next = box_max_row;
    box_seen_next    = box_seen | diff;
    if (diff && !box_seen) begin
      box_min_col_next = x_ext;
      box_min_row_next = y_ext;
      box_max_col_next = col_count;
      box_max_row_next = row_count;
    end else if (diff) begin
      if (x_ext < box_min_col) box_min_col_next = x_ext;
      if (y_ext < box_min_row) box_min_row_next = y_ext;
      if (col_count > box_max_col) box_max_col_next = col_count;
      if (row_count > box_max_row) box_max_row_next = row_count;
    end
  end

  // raster position of the following pair
  always_comb begin
    col_count_next = x_inc[COORD_W-1:0];
    row_count_next = row_count;
    if (x_inc >= dims.w) begin
      col_count_next = '0;
      row_count_next = (y_inc >= dims.h) ? '0 : y_inc[COORD_W-1:0];
    end
  end

  // grow by one pixel per side, clamped to the image
  assign max_col_inc = DIM_W'(box_max_col_next) + DIM_W'(1);
  assign max_row_inc = DIM_W'(box_max_row_next) + DIM_W'(1);

  always_comb begin
    x0 = (box_min_col_next != '0) ? box_min_col_next - DIM_W'(1) : box_min_col_next;
    y0 = (box_min_row_next != '0) ? box_min_row_next - DIM_W'(1) : box_min_row_next;
    x1 = (max_col_inc < dims.w) ? max_col_inc : DIM_W'(box_max_col_next);
    y1 = (max_row_inc < dims.h) ? max_row_inc : DIM_W'(box_max_row_next);
    result = '0;
    if (!box_seen_next) begin
      result.identical = 1'b1;
    end else begin
      result.rect_x = x0[COORD_W-1:0];
      result.rect_y = y0[COORD_W-1:0];
      result.rect_w = x1 - x0 + DIM_W'(1);
      result.rect_h = y1 - y0 + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_col <= eff_dim(RESET_WIDTH);
      box_min_row <= eff_dim(RESET_HEIGHT);
      box_max_col <= '0;
      box_max_row <= '0;
      box_seen    <= 1'b0;
      col_count   <= '0;
      row_count   <= '0;
    end else if (restart || (step && last)) begin
      box_min_col <= restart ? restart_dims.w : dims.w;
      box_min_row <= restart ? restart_dims.h : dims.h;
      box_max_col <= '0;
      box_max_row <= '0;
      box_seen    <= 1'b0;
      col_count   <= '0;
      row_count   <= '0;
    end else if (step) begin
      box_min_col <= box_min_col_next;
      box_min_row <= box_min_row_next;
      box_max_col <= box_max_col_next;
      box_max_row <= box_max_row_next;
      box_seen    <= box_seen_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/image_difference_bounding_box_core.sv =====
// channel | direction | handshake                 | payload
// pixel   | in        | in_valid / in_stall       | ref_pixel, cmp_pixel, end_of_set
// result  | out       | out_valid / out_stall     | identical, rect_x, rect_y, rect_w, rect_h
// config  | in        | apb psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// one pixel pair per clock while in_stall is low; the box update and the result run in a single pass
// from the input ports into the box registers and the result register
// a result appears in the cycle after its end_of_set transaction
// in_stall is high only while a result waits and out_stall holds it
// rst is synchronous: width 640, height 480, box and raster position cleared
// a register write also clears the box and restarts at column 0, row 0
`default_nettype none
`include "image_difference_bounding_box_core_macros.svh"

module image_difference_bounding_box_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [idbb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [idbb_pkg::DATA_W-1:0]  pwdata,
  output logic      [idbb_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                          in_valid,
  output logic                              in_stall,
  input  wire logic [idbb_pkg::PIXEL_W-1:0] ref_pixel,
  input  wire logic [idbb_pkg::PIXEL_W-1:0] cmp_pixel,
  input  wire logic                          end_of_set,
  output logic                              out_valid,
  input  wire logic                          out_stall,
  output logic                              identical,
  output logic      [idbb_pkg::COORD_W-1:0] rect_x,
  output logic      [idbb_pkg::COORD_W-1:0] rect_y,
  output logic      [idbb_pkg::DIM_W-1:0]   rect_w,
  output logic      [idbb_pkg::DIM_W-1:0]   rect_h
);
  import idbb_pkg::*;

  logic [CFG_W-1:0] image_width, image_width_next;
  logic [CFG_W-1:0] image_height, image_height_next;
  reg_addr_t        reg_sel;
  logic             cfg_write;
  dims_t            dims;
  dims_t            restart_dims;
  logic             in_accept;
  result_t          result;
  result_t          out_result;

  assign pready    = 1'b1;
  assign reg_sel   = reg_addr_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    image_width_next  = image_width;
    image_height_next = image_height;
    if (cfg_write) begin
      case (reg_sel)
        REG_WIDTH:  image_width_next  = pwdata[CFG_W-1:0];
        REG_HEIGHT: image_height_next = pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(image_width);
      REG_HEIGHT: prdata = DATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else begin
      image_width  <= image_width_next;
      image_height <= image_height_next;
    end
  end

  assign dims.w         = eff_dim(image_width);
  assign dims.h         = eff_dim(image_height);
  assign restart_dims.w = eff_dim(image_width_next);
  assign restart_dims.h = eff_dim(image_height_next);

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  idbb_tracker u_tracker (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .ref_pixel    (ref_pixel),
    .cmp_pixel    (cmp_pixel),
    .last         (end_of_set),
    .dims         (dims),
    .restart      (cfg_write),
    .restart_dims (restart_dims),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && end_of_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_set) begin
      out_result <= result;
    end
  end

  assign identical = out_result.identical;
  assign rect_x    = out_result.rect_x;
  assign rect_y    = out_result.rect_y;
  assign rect_w    = out_result.rect_w;
  assign rect_h    = out_result.rect_h;

  `IDBB_ASSERT_NEXT(a_last_gives_result, in_valid && !in_stall && end_of_set, out_valid, "end of set transaction did not produce a result")
  `IDBB_ASSERT_IMPL(a_identical_zero_rect, out_valid && identical, rect_x == '0 && rect_y == '0 && rect_w == '0 && rect_h == '0, "identical result carries a nonzero rectangle")
  `IDBB_ASSERT_IMPL(a_rect_nonempty, out_valid && !identical, rect_w != '0 && rect_h != '0, "difference result has an empty rectangle")

endmodule

`default_nettype wire
